### src/paou_pkg.sv
// ----------------------------------------------------------------------------
// paou_pkg: shared definitions for the pixel alpha operation unit
// Operation codes, register map and fixed-point reciprocal constants.
// ----------------------------------------------------------------------------
package paou_pkg;

  typedef enum logic [1:0] {
    OP_OVER   = 2'd0,
    OP_PREMUL = 2'd1,
    OP_DEMUL  = 2'd2,
    OP_ADJUST = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_OPERATION  = 3'd0,
    REG_OVER_RED   = 3'd1,
    REG_OVER_GREEN = 3'd2,
    REG_OVER_BLUE  = 3'd3,
    REG_OVER_ALPHA = 3'd4,
    REG_OVER_PREM  = 3'd5,
    REG_AMOUNT     = 3'd6,
    REG_RELATIVE   = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned NumCh    = 3;    // blue, green, red

  // RGB divide: quotient = (num * recip) >> RcpShift, exact for num < 2^17
  localparam int unsigned NumW     = 17;
  localparam int unsigned RcpShift = 25;
  localparam int unsigned RcpW     = 26;
  localparam int unsigned QuotW    = 17;
  localparam logic [RcpW-1:0] Recip255 = RcpW'((2**RcpShift + 254) / 255);

  // alpha divide by 1000, exact for num < 2^18
  localparam int unsigned ANumW     = 18;
  localparam int unsigned AShift    = 28;
  localparam int unsigned ARcpW     = 19;
  localparam logic [ARcpW-1:0] Recip1000 = ARcpW'((2**AShift + 999) / 1000);
  localparam logic [9:0]  AmountMax = 10'd1000;

endpackage

### src/pixel_alpha_operation_unit.sv
// ----------------------------------------------------------------------------
// pixel_alpha_operation_unit
// Colour-over, premultiply, demultiply and alpha adjust on BGRA pixels.
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// pix     | in        | pix_valid_i / pix_stall_o | pix_blue/green/red/alpha_i
// res     | out       | res_valid_o / res_stall_i | res_blue/green/red/alpha_o
// cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel per clock while the result side does not stall; registered stages
// are products, reciprocal multiply and select/clamp.
// Division uses constant reciprocal tables, 255/1000 fixed, 1/A from a
// 256-entry constant table.
// Stall propagates back stage by stage; empty stages keep filling.
// Reset clears valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module pixel_alpha_operation_unit import paou_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                pix_valid_i,
  output logic                pix_stall_o,
  input  logic [7:0]          pix_blue_i,
  input  logic [7:0]          pix_green_i,
  input  logic [7:0]          pix_red_i,
  input  logic [7:0]          pix_alpha_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output logic [7:0]          res_blue_o,
  output logic [7:0]          res_green_o,
  output logic [7:0]          res_red_o,
  output logic [7:0]          res_alpha_o
);

  // configuration
  op_e                 op_q;
  logic [7:0]          over_c_q [NumCh];
  logic [7:0]          over_alpha_q;
  logic                over_prem_q;
  logic signed [10:0]  amount_q;
  logic                relative_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= OP_OVER;
      over_c_q[0]  <= '0;
      over_c_q[1]  <= '0;
      over_c_q[2]  <= '0;
      over_alpha_q <= '0;
      over_prem_q  <= 1'b0;
      amount_q     <= '0;
      relative_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_OPERATION:  op_q         <= op_e'(cfg_data_i[1:0]);
        REG_OVER_RED:   over_c_q[2]  <= cfg_data_i[7:0];
        REG_OVER_GREEN: over_c_q[1]  <= cfg_data_i[7:0];
        REG_OVER_BLUE:  over_c_q[0]  <= cfg_data_i[7:0];
        REG_OVER_ALPHA: over_alpha_q <= cfg_data_i[7:0];
        REG_OVER_PREM:  over_prem_q  <= cfg_data_i[0];
        REG_AMOUNT:     amount_q     <= signed'(cfg_data_i);
        REG_RELATIVE:   relative_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // 1/A reciprocal table, entry 0 unused
  logic [RcpW-1:0] rcp_tab [256];
  for (genvar i = 0; i < 256; i++) begin : g_rcp
    if (i == 0) begin : g_zero
      assign rcp_tab[i] = '0;
    end else begin : g_val
      localparam logic [RcpW-1:0] RcpVal = RcpW'((2**RcpShift + i - 1) / i);
      assign rcp_tab[i] = RcpVal;
    end
  end

  // stage enables
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3         = !v3_q || !res_stall_i;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign pix_stall_o = !en1;
  assign res_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------- stage 1: numerators ----------------
  logic [7:0]        pix_c [NumCh];
  logic [NumW-1:0]   num_d [NumCh];
  logic [RcpW-1:0]   rcp_d;
  logic [ANumW-1:0]  anum_d;
  logic              aneg_d;
  logic [10:0]       mag11;
  logic [9:0]        mag10;

  assign pix_c[0] = pix_blue_i;
  assign pix_c[1] = pix_green_i;
  assign pix_c[2] = pix_red_i;

  always_comb begin
    logic [7:0]  inv;
    logic [7:0]  wgt;
    logic [15:0] prod_a;
    logic [15:0] prod_b;
    inv = 8'd255 - over_alpha_q;
    wgt = over_prem_q ? 8'd255 : over_alpha_q;
    for (int c = 0; c < NumCh; c++) begin
      prod_a = '0;
      prod_b = '0;
      case (op_q)
        OP_OVER: begin
          prod_a   = over_c_q[c] * wgt;
          prod_b   = pix_c[c] * inv;
          num_d[c] = {1'b0, prod_a} + {1'b0, prod_b} + NumW'(127);
        end
        OP_PREMUL: begin
          prod_a   = pix_c[c] * pix_alpha_i;
          num_d[c] = {1'b0, prod_a} + NumW'(127);
        end
        OP_DEMUL: begin
          prod_a   = pix_c[c] * 8'd255;
          num_d[c] = {1'b0, prod_a} + NumW'(pix_alpha_i[7:1]);
        end
        default: begin
          num_d[c] = '0;
        end
      endcase
    end
    rcp_d = (op_q == OP_DEMUL) ? rcp_tab[pix_alpha_i] : Recip255;
  end

  // alpha amount: clamp magnitude to 1000, absolute mode drops negatives
  assign aneg_d = amount_q[10];
  assign mag11  = aneg_d ? 11'(-amount_q) : 11'(amount_q);
  assign mag10  = (mag11 > 11'(AmountMax)) ? AmountMax : mag11[9:0];

  always_comb begin
    logic [17:0] aprod;
    if (relative_q) begin
      aprod  = pix_alpha_i * mag10;
      anum_d = aprod + ANumW'(500);
    end else begin
      aprod  = aneg_d ? '0 : 8'd255 * mag10;
      anum_d = aprod;
    end
  end

  logic [7:0]       s1_pix_q [NumCh];
  logic [7:0]       s1_alpha_q;
  logic [NumW-1:0]  s1_num_q [NumCh];
  logic [RcpW-1:0]  s1_rcp_q;
  logic [ANumW-1:0] s1_anum_q;
  logic             s1_aneg_q;

  always_ff @(posedge clk_i) begin
    if (en1 && pix_valid_i) begin
      s1_pix_q   <= pix_c;
      s1_alpha_q <= pix_alpha_i;
      s1_num_q   <= num_d;
      s1_rcp_q   <= rcp_d;
      s1_anum_q  <= anum_d;
      s1_aneg_q  <= aneg_d;
    end
  end

  // ---------------- stage 2: reciprocal multiply ----------------
  logic [QuotW-1:0] quot_d [NumCh];
  logic [7:0]       aquot_d;

  always_comb begin
    logic [NumW+RcpW-1:0]   prod;
    logic [ANumW+ARcpW-1:0] aprod;
    for (int c = 0; c < NumCh; c++) begin
      prod      = {{RcpW{1'b0}}, s1_num_q[c]} * {{NumW{1'b0}}, s1_rcp_q};
      quot_d[c] = prod[RcpShift +: QuotW];
    end
    aprod   = {{ARcpW{1'b0}}, s1_anum_q} * {{ANumW{1'b0}}, Recip1000};
    aquot_d = aprod[AShift +: 8];
  end

  logic [7:0]       s2_pix_q [NumCh];
  logic [7:0]       s2_alpha_q;
  logic [QuotW-1:0] s2_quot_q [NumCh];
  logic [7:0]       s2_aquot_q;
  logic             s2_aneg_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      s2_pix_q   <= s1_pix_q;
      s2_alpha_q <= s1_alpha_q;
      s2_quot_q  <= quot_d;
      s2_aquot_q <= aquot_d;
      s2_aneg_q  <= s1_aneg_q;
    end
  end

  // ---------------- stage 3: select and clamp ----------------
  logic [7:0] res_c_d [NumCh];
  logic [7:0] res_a_d;

  always_comb begin
    logic [7:0] sat;
    logic [8:0] asum;
    for (int c = 0; c < NumCh; c++) begin
      sat = (|s2_quot_q[c][QuotW-1:8]) ? 8'd255 : s2_quot_q[c][7:0];
      case (op_q)
        OP_OVER: begin
          if (over_alpha_q == 8'd255)    res_c_d[c] = over_c_q[c];
          else if (over_alpha_q == 8'd0) res_c_d[c] = s2_pix_q[c];
          else                           res_c_d[c] = sat;
        end
        OP_PREMUL, OP_DEMUL: begin
          if (s2_alpha_q == 8'd0)        res_c_d[c] = 8'd0;
          else if (s2_alpha_q == 8'd255) res_c_d[c] = s2_pix_q[c];
          else                           res_c_d[c] = sat;
        end
        default: res_c_d[c] = s2_pix_q[c];
      endcase
    end
    if (s2_aneg_q) asum = {1'b0, s2_alpha_q} - {1'b0, s2_aquot_q};
    else           asum = {1'b0, s2_alpha_q} + {1'b0, s2_aquot_q};
    if (op_q != OP_ADJUST) begin
      res_a_d = s2_alpha_q;
    end else if (!relative_q) begin
      res_a_d = s2_aquot_q;
    end else if (asum[8]) begin
      // borrow on subtract clamps to 0, carry on add clamps to 255
      res_a_d = s2_aneg_q ? 8'd0 : 8'd255;
    end else begin
      res_a_d = asum[7:0];
    end
  end

  logic [7:0] res_c_q [NumCh];
  logic [7:0] res_a_q;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      res_c_q <= res_c_d;
      res_a_q <= res_a_d;
    end
  end

  assign res_blue_o  = res_c_q[0];
  assign res_green_o = res_c_q[1];
  assign res_red_o   = res_c_q[2];
  assign res_alpha_o = res_a_q;

endmodule

### src/paou_chk.sv
// ----------------------------------------------------------------------------
// paou_chk: port-level checks for the pixel alpha operation unit
// Watches handshakes and pipeline flow; attached to the top level by bind.
// ----------------------------------------------------------------------------
module paou_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                pix_valid_i,
  input logic                pix_stall_o,
  input logic                res_valid_o,
  input logic                res_stall_i,
  input logic [7:0]          res_blue_o,
  input logic [7:0]          res_green_o,
  input logic [7:0]          res_red_o,
  input logic [7:0]          res_alpha_o
);

  // no beat leaves while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !res_valid_o)
    else $error("result valid during reset");

  // a stalled result beat stays put
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(res_blue_o)
      && $stable(res_green_o) && $stable(res_red_o) && $stable(res_alpha_o))
    else $error("stalled result beat changed");

  // a free output never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_stall_i |-> !pix_stall_o)
    else $error("input stalled while output free");

  // an accepted pixel reaches the output when the result side does not stall
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_i && !pix_stall_o) ##1 !res_stall_i ##1 !res_stall_i
      |=> res_valid_o)
    else $error("pixel lost in pipeline");

endmodule

bind pixel_alpha_operation_unit paou_chk u_paou_chk (.*);

### bench/pixel_alpha_operation_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_alpha_operation_unit_test
// Streams BGRA pixels through colour-over, premultiply, demultiply and alpha
// adjust under many register settings, with random gaps and stalls on both
// sides. Each result beat is checked against a local pixel predictor.
// ----------------------------------------------------------------------------
module pixel_alpha_operation_unit_test;
  import paou_pkg::*;

  localparam int HoldOffCycles = 60;
  localparam int SettleCycles  = 10;
  localparam int PhaseCount    = 16;
  localparam int PhasePixels   = 120;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } bgra_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                pix_valid_i = 1'b0;
  logic                pix_stall_o;
  logic [7:0]          pix_blue_i  = '0;
  logic [7:0]          pix_green_i = '0;
  logic [7:0]          pix_red_i   = '0;
  logic [7:0]          pix_alpha_i = '0;
  logic                res_valid_o;
  logic                res_stall_i = 1'b0;
  logic [7:0]          res_blue_o;
  logic [7:0]          res_green_o;
  logic [7:0]          res_red_o;
  logic [7:0]          res_alpha_o;

  // register shadow used by the predictor
  op_e                cur_op     = OP_OVER;
  logic [7:0]         ov_red     = '0;
  logic [7:0]         ov_green   = '0;
  logic [7:0]         ov_blue    = '0;
  logic [7:0]         ov_alpha   = '0;
  logic               ov_prem    = 1'b0;
  logic signed [10:0] amount     = '0;
  logic               amount_rel = 1'b0;

  bgra_t pixels_to_send[$];
  bgra_t expected_pixels[$];

  int pix_wait      = 0;
  int pix_gap_max   = 0;
  int res_wait      = 0;
  int res_stall_max = 0;
  int res_hold      = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int err_cnt       = 0;

  pixel_alpha_operation_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (pix_valid_i),
    .pix_stall_o (pix_stall_o),
    .pix_blue_i  (pix_blue_i),
    .pix_green_i (pix_green_i),
    .pix_red_i   (pix_red_i),
    .pix_alpha_i (pix_alpha_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_blue_o  (res_blue_o),
    .res_green_o (res_green_o),
    .res_red_o   (res_red_o),
    .res_alpha_o (res_alpha_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] over_channel(int unsigned c, int unsigned p);
    int unsigned inv;
    int unsigned v;
    inv = 255 - ov_alpha;
    if (ov_prem) begin
      v = (c * 255 + inv * p + 127) / 255;
      if (v > 255) v = 255;
    end else begin
      v = (c * ov_alpha + inv * p + 127) / 255;
    end
    return v[7:0];
  endfunction

  function automatic logic [7:0] premul_channel(int unsigned p, int unsigned a);
    int unsigned v;
    v = (p * a + 127) / 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] demul_channel(int unsigned p, int unsigned a);
    int unsigned v;
    v = (p * 255 + a / 2) / a;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic bgra_t process_pixel(bgra_t px);
    bgra_t q;
    int    n;
    int    a_in;
    int    prod;
    int    qv;
    q = px;
    a_in = px.alpha;
    case (cur_op)
      OP_OVER: begin
        if (ov_alpha == 8'd255) begin
          q.blue  = ov_blue;
          q.green = ov_green;
          q.red   = ov_red;
        end else if (ov_alpha != 8'd0) begin
          q.blue  = over_channel(ov_blue, px.blue);
          q.green = over_channel(ov_green, px.green);
          q.red   = over_channel(ov_red, px.red);
        end
      end
      OP_PREMUL, OP_DEMUL: begin
        if (px.alpha == 8'd0) begin
          q.blue  = '0;
          q.green = '0;
          q.red   = '0;
        end else if (px.alpha != 8'd255) begin
          if (cur_op == OP_PREMUL) begin
            q.blue  = premul_channel(px.blue, a_in);
            q.green = premul_channel(px.green, a_in);
            q.red   = premul_channel(px.red, a_in);
          end else begin
            q.blue  = demul_channel(px.blue, a_in);
            q.green = demul_channel(px.green, a_in);
            q.red   = demul_channel(px.red, a_in);
          end
        end
      end
      default: begin
        n = amount;
        if (!amount_rel) begin
          if (n < 0) n = 0;
          if (n > 1000) n = 1000;
          qv = (255 * n) / 1000;
        end else begin
          if (n < -1000) n = -1000;
          if (n > 1000) n = 1000;
          prod = a_in * n;
          // halves round away from zero
          if (prod >= 0) qv = (prod + 500) / 1000;
          else qv = -((-prod + 500) / 1000);
          qv = qv + a_in;
          if (qv < 0) qv = 0;
          if (qv > 255) qv = 255;
        end
        q.alpha = qv[7:0];
      end
    endcase
    return q;
  endfunction

  // ---------------------------------------------------------------- pixel driver
  always @(posedge clk_i) begin : drive_pixels
    bgra_t px;
    logic  valid_nxt;
    valid_nxt = pix_valid_i;
    if (pix_valid_i && !pix_stall_o) begin
      px = '{pix_blue_i, pix_green_i, pix_red_i, pix_alpha_i};
      expected_pixels.push_back(process_pixel(px));
      valid_nxt = 1'b0;
    end
    if (!valid_nxt && rst_ni) begin
      if (pix_wait > 0) begin
        pix_wait--;
      end else if (pixels_to_send.size() != 0) begin
        px = pixels_to_send.pop_front();
        pix_blue_i  <= px.blue;
        pix_green_i <= px.green;
        pix_red_i   <= px.red;
        pix_alpha_i <= px.alpha;
        valid_nxt = 1'b1;
        pix_wait = (pix_gap_max == 0) ? 0 : $urandom_range(0, pix_gap_max);
      end
    end
    pix_valid_i <= valid_nxt;
  end

  // ---------------------------------------------------------------- result monitor
  task automatic note_failure(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin : collect_results
    bgra_t got;
    bgra_t want;
    logic  stall_nxt;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      got = '{res_blue_o, res_green_o, res_red_o, res_alpha_o};
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("unexpected result beat b=%0d g=%0d r=%0d a=%0d",
                               got.blue, got.green, got.red, got.alpha));
      end else begin
        want = expected_pixels.pop_front();
        if (got.blue !== want.blue || got.green !== want.green ||
            got.red !== want.red || got.alpha !== want.alpha)
          note_failure($sformatf(
            "pixel mismatch: expected b=%0d g=%0d r=%0d a=%0d, got b=%0d g=%0d r=%0d a=%0d",
            want.blue, want.green, want.red, want.alpha,
            got.blue, got.green, got.red, got.alpha));
      end
      res_wait = (res_stall_max == 0) ? 0 : $urandom_range(0, res_stall_max);
    end
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      res_hold = HoldOffCycles;
    end
    if (res_hold > 0) begin
      res_hold--;
      stall_nxt = 1'b1;
    end else if (res_wait > 0) begin
      res_wait--;
      stall_nxt = 1'b1;
    end else begin
      stall_nxt = 1'b0;
    end
    res_stall_i <= stall_nxt;
  end

  // ---------------------------------------------------------------- stimulus
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pixels_to_send.size() != 0 || pix_valid_i || expected_pixels.size() != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      REG_OPERATION:  cur_op     = op_e'(data[1:0]);
      REG_OVER_RED:   ov_red     = data[7:0];
      REG_OVER_GREEN: ov_green   = data[7:0];
      REG_OVER_BLUE:  ov_blue    = data[7:0];
      REG_OVER_ALPHA: ov_alpha   = data[7:0];
      REG_OVER_PREM:  ov_prem    = data[0];
      REG_AMOUNT:     amount     = signed'(data);
      REG_RELATIVE:   amount_rel = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_settings(logic [10:0] op, logic [10:0] red, logic [10:0] green,
                               logic [10:0] blue, logic [10:0] alpha, logic [10:0] prem,
                               logic [10:0] amt, logic [10:0] rel);
    wait_idle();
    write_reg(REG_OPERATION, op);
    write_reg(REG_OVER_RED, red);
    write_reg(REG_OVER_GREEN, green);
    write_reg(REG_OVER_BLUE, blue);
    write_reg(REG_OVER_ALPHA, alpha);
    write_reg(REG_OVER_PREM, prem);
    write_reg(REG_AMOUNT, amt);
    write_reg(REG_RELATIVE, rel);
  endtask

  function automatic void queue_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                      logic [7:0] a);
    pixels_to_send.push_back('{b, g, r, a});
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  // unused upper data bits carry noise; the register must ignore them
  function automatic logic [10:0] noisy(logic [10:0] val, int w);
    return (11'($urandom) << w) | val;
  endfunction

  initial begin : stimulus
    logic [10:0] amt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: colour-over with overlay alpha zero leaves pixels alone
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd255);

    // opaque overlay replaces RGB
    load_settings(OP_OVER, 11'd255, 11'd0, 11'd128, 11'd255, 11'd0, 11'd0, 11'd0);
    queue_pixel(8'd10, 8'd20, 8'd30, 8'd40);
    queue_pixel(8'd255, 8'd0, 8'd255, 8'd0);

    // premultiplied blend, clamp at full scale
    load_settings(OP_OVER, 11'd255, 11'd255, 11'd255, 11'd100, 11'd1, 11'd0, 11'd0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd255);

    // straight blend, faintest overlay
    load_settings(OP_OVER, 11'd0, 11'd77, 11'd200, 11'd1, 11'd0, 11'd0, 11'd0);
    queue_pixel(8'd255, 8'd1, 8'd0, 8'd9);
    queue_pixel(8'd128, 8'd254, 8'd77, 8'd200);

    load_settings(OP_PREMUL, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd0);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd255);
    queue_pixel(8'd255, 8'd128, 8'd1, 8'd128);
    queue_pixel(8'd255, 8'd254, 8'd3, 8'd1);

    // demultiply, including saturation where channel exceeds alpha
    load_settings(OP_DEMUL, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd0);
    queue_pixel(8'd200, 8'd100, 8'd50, 8'd255);
    queue_pixel(8'd255, 8'd1, 8'd0, 8'd1);
    queue_pixel(8'd100, 8'd200, 8'd50, 8'd200);

    // absolute alpha: clamp below, clamp above, mid value
    load_settings(OP_ADJUST, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'(-1024), 11'd0);
    queue_pixel(8'd1, 8'd2, 8'd3, 8'd128);
    load_settings(OP_ADJUST, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd1023, 11'd0);
    queue_pixel(8'd1, 8'd2, 8'd3, 8'd0);
    load_settings(OP_ADJUST, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd500, 11'd0);
    queue_pixel(8'd255, 8'd255, 8'd255, 8'd77);

    // relative alpha: clamps and rounding of halves in both directions
    load_settings(OP_ADJUST, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'(-1024), 11'd1);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd255);
    load_settings(OP_ADJUST, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd1023, 11'd1);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd200);
    load_settings(OP_ADJUST, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd2, 11'd1);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd250);
    load_settings(OP_ADJUST, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'(-2), 11'd1);
    queue_pixel(8'd0, 8'd0, 8'd0, 8'd250);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case ($urandom_range(0, 6))
        0: amt = 11'(-1024);
        1: amt = 11'd1023;
        2: amt = 11'(-1000);
        3: amt = 11'd1000;
        4: amt = 11'(int'($urandom_range(0, 20)) - 10);
        default: amt = 11'($urandom);
      endcase
      load_settings(noisy(11'(ph % 4), 2), noisy(pick_byte(), 8), noisy(pick_byte(), 8),
                    noisy(pick_byte(), 8), noisy(pick_byte(), 8),
                    noisy(11'($urandom_range(0, 1)), 1), amt,
                    noisy(11'($urandom_range(0, 1)), 1));
      pix_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 8;
      res_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      if (ph == 0) begin
        pix_gap_max   = 0;
        res_stall_max = 0;
      end
      if (ph == 5) begin
        // long receiver hold-off while the sender keeps pushing
        pix_gap_max = 0;
        hold_req++;
      end
      for (int i = 0; i < PhasePixels; i++) begin
        // mid-phase the sender stops until the pipe has drained
        if (ph == 9 && i == PhasePixels / 2) wait_idle();
        queue_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && expected_pixels.size() == 0) begin
      $display("PASS pixel_alpha_operation_unit");
    end else begin
      $display("FAIL pixel_alpha_operation_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("FAIL pixel_alpha_operation_unit");
    $finish;
  end

endmodule
